@@ hw/rtl/edbp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and saturating arithmetic for the error-diffusion
// bitmap packer. No dependencies.
package edbp_pkg;

  localparam int unsigned MaxWidthDefault = 1024;

  localparam int GrayW      = 8;
  localparam int ErrW       = 11;
  localparam int StoreW     = 10;
  localparam int WideW      = 14;
  localparam int WidthRegW  = 11;
  localparam int HeightRegW = 16;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 16;

  localparam int ErrMax   = 2 ** (ErrW - 1) - 1;
  localparam int ErrMin   = -(2 ** (ErrW - 1));
  localparam int StoreMax = 2 ** (StoreW - 1) - 1;
  localparam int StoreMin = -(2 ** (StoreW - 1));

  localparam int ThreshLevel = 128;
  localparam int FullLevel   = 255;
  localparam int DiffDiv     = 16;

  localparam logic [7:0] MsbMask  = 8'h80;
  localparam logic [7:0] LsbMask  = 8'h01;
  localparam logic [7:0] ByteMask = 8'hFF;

  localparam logic [HeightRegW-1:0] ResetHeight = 16'd480;
  localparam logic [WidthRegW-1:0]  ResetWidth  = 11'd640;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth   = 3'd0,
    CfgImageHeight  = 3'd1,
    CfgDitherEnable = 3'd2,
    CfgMsbFirst     = 3'd3,
    CfgInvertOutput = 3'd4
  } cfg_idx_e;

  typedef logic signed [ErrW-1:0]   err_t;
  typedef logic signed [StoreW-1:0] store_t;
  typedef logic signed [WideW-1:0]  wide_t;

  // Position of a pixel in the frame, resolved when the item is taken in.
  typedef struct packed {
    logic first_row;
    logic first_col;
    logic last_col;
    logic last_row;
  } pix_ctl_t;

  // Line store updates produced by one pixel: below-left entry (a) and the
  // row's last entry (b).
  typedef struct packed {
    logic   a_we;
    store_t a_data;
    logic   b_we;
    store_t b_data;
  } store_wr_t;

  function automatic err_t sat_err(input wide_t x);
    err_t r;
    if (x > wide_t'(ErrMax)) begin
      r = err_t'(ErrMax);
    end else if (x < wide_t'(ErrMin)) begin
      r = err_t'(ErrMin);
    end else begin
      r = x[ErrW-1:0];
    end
    return r;
  endfunction

  function automatic store_t sat_store(input wide_t x);
    store_t r;
    if (x > wide_t'(StoreMax)) begin
      r = store_t'(StoreMax);
    end else if (x < wide_t'(StoreMin)) begin
      r = store_t'(StoreMin);
    end else begin
      r = x[StoreW-1:0];
    end
    return r;
  endfunction

  // Divide by sixteen, truncating toward zero.
  function automatic wide_t div16(input wide_t x);
    wide_t bias;
    bias = x[WideW-1] ? wide_t'(DiffDiv - 1) : '0;
    return (x + bias) >>> 4;
  endfunction

endpackage

@@ hw/rtl/edbp_line_store.sv @@
`timescale 1ns / 1ps
// Line store for the error owed to the next row: one write port, one
// registered read port. Depends on edbp_pkg.
module edbp_line_store import edbp_pkg::*; #(
  parameter int unsigned DEPTH = MaxWidthDefault,
  parameter int          AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  store_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output store_t        rdata_o
);

  store_t mem [DEPTH];
  store_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Hold the read data until the next read so a stalled pixel keeps it.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/edbp_diffuser.sv @@
`timescale 1ns / 1ps
// Threshold and Floyd-Steinberg error spreading for one pixel, with the
// right carry and the pending below-row sums. Depends on edbp_pkg.
module edbp_diffuser import edbp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic [GrayW-1:0] gray_i,
  input  pix_ctl_t         ctl_i,
  input  store_t           store_val_i,
  input  logic             dither_i,
  output logic             bit_o,
  output store_wr_t        wr_o
);

  store_t rc_q, rc_d;
  err_t   pb0_q, pb0_d;
  err_t   pb1_q, pb1_d;

  wide_t  v_sum;
  err_t   v;
  err_t   e;
  wide_t  e_w;
  wide_t  q7, q5, q3, q1;
  err_t   pb0_mid;

  always_comb begin
    v_sum = wide_t'({1'b0, gray_i});
    if (dither_i && !ctl_i.first_row) begin
      v_sum = v_sum + wide_t'(store_val_i);
    end
    if (dither_i) begin
      v_sum = v_sum + wide_t'(rc_q);
    end
    v     = sat_err(v_sum);
    bit_o = (v >= err_t'(ThreshLevel));

    if (!dither_i) begin
      e = '0;
    end else if (bit_o) begin
      e = sat_err(wide_t'(v) - wide_t'(FullLevel));
    end else begin
      e = v;
    end
    e_w = wide_t'(e);

    q7 = div16((e_w <<< 3) - e_w);
    q5 = div16((e_w <<< 2) + e_w);
    q3 = div16((e_w <<< 1) + e_w);
    q1 = div16(e_w);

    pb0_mid = sat_err(wide_t'(pb1_q) + q5);

    wr_o.a_we   = !ctl_i.last_row && !ctl_i.first_col;
    wr_o.a_data = sat_store(wide_t'(pb0_q) + q3);
    wr_o.b_we   = !ctl_i.last_row && ctl_i.last_col;
    wr_o.b_data = sat_store(wide_t'(pb0_mid));

    rc_d = ctl_i.last_col ? '0 : sat_store(q7);
    if (ctl_i.last_row || ctl_i.last_col) begin
      pb0_d = '0;
      pb1_d = '0;
    end else begin
      pb0_d = pb0_mid;
      pb1_d = sat_err(q1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q  <= '0;
      pb0_q <= '0;
      pb1_q <= '0;
    end else if (advance_i) begin
      rc_q  <= rc_d;
      pb0_q <= pb0_d;
      pb1_q <= pb1_d;
    end
  end

endmodule

@@ hw/rtl/edbp_packer.sv @@
`timescale 1ns / 1ps
// Bit packing into bytes and the output register of the result channel.
// Depends on edbp_pkg.
module edbp_packer import edbp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  logic       bit_i,
  input  pix_ctl_t   ctl_i,
  input  logic       msb_first_i,
  input  logic       invert_i,
  output logic       can_take_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] packed_byte_o,
  output logic       row_end_o,
  output logic       frame_end_o
);

  logic [7:0] acc_q, acc_d;
  logic [2:0] pos_q, pos_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q;
  logic       row_end_q, frame_end_q;

  logic       emit;
  logic [7:0] acc_bit;
  logic [7:0] pos_mask;

  always_comb begin
    emit       = (pos_q == 3'd7) || ctl_i.last_col;
    can_take_o = !emit || !out_valid_q || out_ready_i;
    pos_mask   = msb_first_i ? (MsbMask >> pos_q) : (LsbMask << pos_q);
    acc_bit    = bit_i ? (acc_q | pos_mask) : acc_q;

    acc_d       = acc_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (advance_i) begin
      if (emit) begin
        acc_d       = '0;
        pos_d       = '0;
        out_valid_d = 1'b1;
      end else begin
        acc_d = acc_bit;
        pos_d = pos_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && emit) begin
      byte_q      <= invert_i ? (acc_bit ^ ByteMask) : acc_bit;
      row_end_q   <= ctl_i.last_col;
      frame_end_q <= ctl_i.last_col && ctl_i.last_row;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign packed_byte_o = byte_q;
  assign row_end_o     = row_end_q;
  assign frame_end_o   = frame_end_q;

endmodule

@@ hw/rtl/error_diffusion_bitmap_packer.sv @@
`timescale 1ns / 1ps
// Top level of the error-diffusion bitmap packer. Depends on edbp_pkg,
// edbp_line_store, edbp_diffuser and edbp_packer.
//
// Feed 8-bit gray pixels in raster order on the input channel
// (in_valid_i / in_ready_o / gray_level_i). Every eighth pixel of a row, and
// the last pixel of each row, yields one packed byte item on the output
// channel (out_valid_o / out_ready_i) with row_end_o and frame_end_o; a row of
// W pixels gives ceil(W/8) bytes, the final one possibly partial.
// Timing: one pixel per clock sustained unless a byte is held up at the output (see Stall). A
// pixel taken in is held in the compute stage registers; its byte, if any, goes
// into the output register when that pixel advances. The right-carry loop of the diffuser and
// the single read and write port of the line store set this rate.
// Stall: with a byte waiting and out_ready_i low, pixels that produce no byte
// keep flowing; a pixel that would produce a byte holds in the compute stage
// and in_ready_o drops until the byte is taken.
// Reset: asynchronous, active low. Counters, carries and configuration return
// to their defaults (640 x 480, dither on, MSB first, no invert). The line
// store is not cleared: the first row of a frame never reads it.
// Configuration: write only while idle; 0 width, 1 height, 2 dither, 3 MSB first, 4 invert.
module error_diffusion_bitmap_packer import edbp_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MaxWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [GrayW-1:0]    gray_level_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          packed_byte_o,
  output logic                row_end_o,
  output logic                frame_end_o
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int CmpW = (ColW + 1 > WidthRegW) ? ColW + 1 : WidthRegW;

  // Configuration registers.
  logic [WidthRegW-1:0]  width_q;
  logic [HeightRegW-1:0] height_q;
  logic                  dither_q;
  logic                  msb_first_q;
  logic                  invert_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= ResetWidth;
      height_q    <= ResetHeight;
      dither_q    <= 1'b1;
      msb_first_q <= 1'b1;
      invert_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgImageWidth:   width_q     <= cfg_wdata_i[WidthRegW-1:0];
        CfgImageHeight:  height_q    <= cfg_wdata_i[HeightRegW-1:0];
        CfgDitherEnable: dither_q    <= cfg_wdata_i[0];
        CfgMsbFirst:     msb_first_q <= cfg_wdata_i[0];
        CfgInvertOutput: invert_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Frame position, resolved at input time.
  logic [ColW-1:0]       col_q, col_d;
  logic [HeightRegW-1:0] row_q, row_d;
  logic [CmpW-1:0]       w_ext, w_eff;
  logic [ColW-1:0]       last_idx;
  logic [HeightRegW-1:0] h_last;
  logic [ColW-1:0]       col_cur;
  logic                  last_col_in, last_row_in;
  logic                  in_acc;

  always_comb begin
    w_ext = CmpW'(width_q);
    if (width_q == '0) begin
      w_eff = CmpW'(1);
    end else if (w_ext > CmpW'(MAX_WIDTH)) begin
      w_eff = CmpW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    last_idx    = ColW'(w_eff - CmpW'(1));
    h_last      = (height_q == '0) ? '0 : height_q - 16'd1;
    last_col_in = (col_q >= last_idx);
    last_row_in = (row_q >= h_last);
    col_cur     = last_col_in ? last_idx : col_q;

    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      col_d = last_col_in ? '0 : col_cur + ColW'(1);
      if (last_col_in) begin
        row_d = last_row_in ? '0 : row_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Compute stage registers.
  logic             s1_valid_q, s1_valid_d;
  logic [GrayW-1:0] s1_gray_q;
  logic [ColW-1:0]  s1_col_q;
  pix_ctl_t         s1_ctl_q;
  logic             byp_hit_q;
  store_t           byp_data_q;
  logic             s1_adv;
  logic             pk_can_take;

  assign s1_adv     = s1_valid_q && pk_can_take;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Line store writes: the below-left entry goes straight in; the last
  // entry of a row waits in the defer register and drains on the next cycle
  // without a below-left write (the next pixel starts a row, so it has none).
  store_wr_t       wr;
  logic [ColW-1:0] a_addr;
  logic            a_fire, b_fire;
  logic            defer_valid_q, defer_valid_d;
  logic [ColW-1:0] defer_addr_q, defer_addr_d;
  store_t          defer_data_q, defer_data_d;
  logic            mem_we;
  logic [ColW-1:0] mem_waddr;
  store_t          mem_wdata;
  store_t          mem_rdata;
  logic            byp_hit_d;
  store_t          byp_data_d;
  store_t          store_val;

  always_comb begin
    a_addr = s1_col_q - ColW'(1);
    a_fire = s1_adv && wr.a_we;
    b_fire = s1_adv && wr.b_we;

    mem_we    = a_fire || defer_valid_q;
    mem_waddr = a_fire ? a_addr : defer_addr_q;
    mem_wdata = a_fire ? wr.a_data : defer_data_q;

    defer_valid_d = defer_valid_q;
    defer_addr_d  = defer_addr_q;
    defer_data_d  = defer_data_q;
    if (b_fire) begin
      defer_valid_d = 1'b1;
      defer_addr_d  = s1_col_q;
      defer_data_d  = wr.b_data;
    end else if (!a_fire) begin
      defer_valid_d = 1'b0;
    end

    // The read launched this edge sees the old contents; forward anything
    // written at this edge or still parked in the defer register.
    byp_hit_d  = 1'b1;
    byp_data_d = defer_data_q;
    if (b_fire && (s1_col_q == col_cur)) begin
      byp_data_d = wr.b_data;
    end else if (a_fire && (a_addr == col_cur)) begin
      byp_data_d = wr.a_data;
    end else if (defer_valid_q && (defer_addr_q == col_cur)) begin
      byp_data_d = defer_data_q;
    end else begin
      byp_hit_d = 1'b0;
    end

    store_val = byp_hit_q ? byp_data_q : mem_rdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      defer_valid_q <= 1'b0;
    end else begin
      defer_valid_q <= defer_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    defer_addr_q <= defer_addr_d;
    defer_data_q <= defer_data_d;
    if (in_acc) begin
      s1_gray_q          <= gray_level_i;
      s1_col_q           <= col_cur;
      s1_ctl_q.first_row <= (row_q == '0);
      s1_ctl_q.first_col <= (col_cur == '0);
      s1_ctl_q.last_col  <= last_col_in;
      s1_ctl_q.last_row  <= last_row_in;
      byp_hit_q          <= byp_hit_d;
      byp_data_q         <= byp_data_d;
    end
  end

  edbp_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (ColW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (in_acc),
    .raddr_i (col_cur),
    .rdata_o (mem_rdata)
  );

  logic pix_bit;

  edbp_diffuser u_diffuser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (s1_adv),
    .gray_i      (s1_gray_q),
    .ctl_i       (s1_ctl_q),
    .store_val_i (store_val),
    .dither_i    (dither_q),
    .bit_o       (pix_bit),
    .wr_o        (wr)
  );

  edbp_packer u_packer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (s1_adv),
    .bit_i         (pix_bit),
    .ctl_i         (s1_ctl_q),
    .msb_first_i   (msb_first_q),
    .invert_i      (invert_q),
    .can_take_o    (pk_can_take),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .packed_byte_o (packed_byte_o),
    .row_end_o     (row_end_o),
    .frame_end_o   (frame_end_o)
  );

endmodule

@@ tb/edbp_dither_checker.sv @@
`timescale 1ns / 1ps
// Byte checker for the error-diffusion bitmap packer: mirrors the dither and
// packing state, predicts every packed byte and compares. Depends on edbp_pkg.
module edbp_dither_checker import edbp_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MaxWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [GrayW-1:0]    gray_level_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [7:0]          packed_byte_i,
  input  logic                row_end_i,
  input  logic                frame_end_i,
  output int                  mismatch_count_o,
  output int                  bytes_pending_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       row_end;
    logic       frame_end;
  } bitmap_byte_t;

  // Register shadow
  logic [WidthRegW-1:0]  width_reg;
  logic [HeightRegW-1:0] height_reg;
  logic                  dither_on;
  logic                  msb_on;
  logic                  invert_on;

  // Diffusion and packing state
  store_t      line_err [MAX_WIDTH];
  store_t      carry_right;
  err_t        below_sum [2];
  logic [7:0]  byte_acc;
  logic [3:0]  bit_cnt;
  int unsigned col_pos;
  logic [15:0] row_pos;

  bitmap_byte_t expected_bytes [$];
  int           mismatches = 0;

  assign mismatch_count_o = mismatches;

  initial begin
    foreach (line_err[k]) line_err[k] = '0;
  end

  function automatic int saturate(input int v, input int bits);
    int hi;
    int lo;
    hi = (1 << (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  task automatic dither_pixel(input logic [7:0] gray);
    int w;
    int h;
    int c;
    int v;
    int e;
    int bl;
    int idx;
    bit last_c;
    bit last_r;
    bit px_on;
    bitmap_byte_t res;
    w = int'(width_reg);
    if (w == 0) w = 1;
    if (w > int'(MAX_WIDTH)) w = MAX_WIDTH;
    h = int'(height_reg);
    if (h == 0) h = 1;
    c = int'(col_pos);
    if (c >= w) c = w - 1;
    last_c = (c >= w - 1);
    last_r = (int'(row_pos) >= h - 1);

    v = int'(gray);
    if (dither_on) begin
      if (row_pos != 0) v += int'(line_err[c]);
      v += int'(carry_right);
    end
    v = saturate(v, ErrW);
    if (v >= ThreshLevel) begin
      e = saturate(v - FullLevel, ErrW);
      px_on = 1'b1;
    end else begin
      e = v;
      px_on = 1'b0;
    end
    if (!dither_on) e = 0;

    // 7/16 to the right
    carry_right = last_c ? '0 : store_t'(saturate((7 * e) / DiffDiv, StoreW));

    // 3/16, 5/16, 1/16 into the next row
    if (!last_r) begin
      bl = int'(below_sum[0]) + (3 * e) / DiffDiv;
      if (c > 0) line_err[c - 1] = store_t'(saturate(bl, StoreW));
      below_sum[0] = err_t'(saturate(int'(below_sum[1]) + (5 * e) / DiffDiv, ErrW));
      below_sum[1] = last_c ? '0 : err_t'(saturate(e / DiffDiv, ErrW));
      if (last_c) begin
        line_err[c] = store_t'(saturate(int'(below_sum[0]), StoreW));
        below_sum[0] = '0;
      end
    end else begin
      below_sum[0] = '0;
      below_sum[1] = '0;
    end

    if (px_on) begin
      idx = msb_on ? 7 - int'(bit_cnt[2:0]) : int'(bit_cnt[2:0]);
      byte_acc[idx] = 1'b1;
    end
    bit_cnt = bit_cnt + 4'd1;

    if (bit_cnt >= 4'd8 || last_c) begin
      res.data      = invert_on ? (byte_acc ^ ByteMask) : byte_acc;
      res.row_end   = last_c;
      res.frame_end = last_c && last_r;
      expected_bytes.push_back(res);
      byte_acc = '0;
      bit_cnt  = '0;
      if (last_c) begin
        col_pos      = 0;
        below_sum[0] = '0;
        below_sum[1] = '0;
        carry_right  = '0;
        row_pos      = last_r ? 16'd0 : row_pos + 16'd1;
      end else begin
        col_pos = c + 1;
      end
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic check_byte();
    bitmap_byte_t want;
    if (expected_bytes.size() == 0) begin
      if (mismatches < 10) begin
        $display("[%0t] unexpected byte %02h row_end %0b frame_end %0b", $time,
                 packed_byte_i, row_end_i, frame_end_i);
      end
      mismatches++;
    end else begin
      want = expected_bytes.pop_front();
      if (want.data !== packed_byte_i || want.row_end !== row_end_i ||
          want.frame_end !== frame_end_i) begin
        if (mismatches < 10) begin
          $display("[%0t] byte mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b", $time,
                   want.data, want.row_end, want.frame_end,
                   packed_byte_i, row_end_i, frame_end_i);
        end
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg    = ResetWidth;
      height_reg   = ResetHeight;
      dither_on    = 1'b1;
      msb_on       = 1'b1;
      invert_on    = 1'b0;
      carry_right  = '0;
      below_sum[0] = '0;
      below_sum[1] = '0;
      byte_acc     = '0;
      bit_cnt      = '0;
      col_pos      = 0;
      row_pos      = '0;
      expected_bytes.delete();
      bytes_pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgImageWidth:   width_reg  = cfg_wdata_i[WidthRegW-1:0];
          CfgImageHeight:  height_reg = cfg_wdata_i[HeightRegW-1:0];
          CfgDitherEnable: dither_on  = cfg_wdata_i[0];
          CfgMsbFirst:     msb_on     = cfg_wdata_i[0];
          CfgInvertOutput: invert_on  = cfg_wdata_i[0];
          default: ;
        endcase
      end
      // compare before predicting: a byte never leaves in its pixel's own cycle
      if (out_valid_i && out_ready_i) check_byte();
      if (in_valid_i && in_ready_i) dither_pixel(gray_level_i);
      bytes_pending_o <= expected_bytes.size();
    end
  end

endmodule

@@ tb/error_diffusion_bitmap_packer_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the error-diffusion bitmap packer: drives pixels and
// register writes, and gives the verdict. Depends on edbp_pkg, the block
// and edbp_dither_checker.
module error_diffusion_bitmap_packer_tb import edbp_pkg::*;;

  localparam int unsigned LineWidth = MaxWidthDefault;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i  = '0;
  logic [CfgDataW-1:0] cfg_wdata_i  = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic [GrayW-1:0]    gray_level_i = '0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic [7:0]          packed_byte_o;
  logic                row_end_o;
  logic                frame_end_o;

  int fail_count;
  int bytes_pending;

  // Idle percentages for the current phase
  int send_gap_pct = 0;
  int stall_pct    = 0;

  // Where the block stands in the frame, and the registers as last written.
  // Used only to decide when a geometry change is safe.
  int               col_at = 0;
  int               row_at = 0;
  logic [10:0]      width_now  = ResetWidth;
  logic [15:0]      height_now = ResetHeight;
  logic             dither_now = 1'b1;
  logic             msb_now    = 1'b1;
  logic             invert_now = 1'b0;

  always #5 clk_i = ~clk_i;

  error_diffusion_bitmap_packer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .gray_level_i  (gray_level_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .packed_byte_o (packed_byte_o),
    .row_end_o     (row_end_o),
    .frame_end_o   (frame_end_o)
  );

  edbp_dither_checker #(.MAX_WIDTH(LineWidth)) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .gray_level_i     (gray_level_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .packed_byte_i    (packed_byte_o),
    .row_end_i        (row_end_o),
    .frame_end_i      (frame_end_o),
    .mismatch_count_o (fail_count),
    .bytes_pending_o  (bytes_pending)
  );

  // Receiver: stall at random at the phase's rate; zero means always ready.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Write all five registers back to back, then drop the write enable once.
  // Unused upper data bits carry random junk; the block must ignore them.
  task automatic load_regs(input logic [10:0] w, input logic [15:0] h,
                           input logic d, input logic m, input logic inv);
    width_now  = w;
    height_now = h;
    dither_now = d;
    msb_now    = m;
    invert_now = inv;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgImageWidth;
    cfg_wdata_i <= {5'($urandom), w};
    @(posedge clk_i);
    cfg_index_i <= CfgImageHeight;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_index_i <= CfgDitherEnable;
    cfg_wdata_i <= {15'($urandom), d};
    @(posedge clk_i);
    cfg_index_i <= CfgMsbFirst;
    cfg_wdata_i <= {15'($urandom), m};
    @(posedge clk_i);
    cfg_index_i <= CfgInvertOutput;
    cfg_wdata_i <= {15'($urandom), inv};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one pixel item and hold it until accepted. Afterwards either keep
  // valid high for the next item or drop it for a random gap.
  task automatic push_pixel(input logic [7:0] g);
    int w;
    int h;
    int c;
    in_valid_i   <= 1'b1;
    gray_level_i <= g;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // advance the frame position, clamping the column as the block does
    w = (width_now == 0) ? 1 : int'(width_now);
    if (w > int'(LineWidth)) w = LineWidth;
    h = (height_now == 0) ? 1 : int'(height_now);
    c = (col_at >= w) ? w - 1 : col_at;
    if (c >= w - 1) begin
      col_at = 0;
      row_at = (row_at >= h - 1) ? 0 : row_at + 1;
    end else begin
      col_at = c + 1;
    end
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_gap_pct) @(posedge clk_i);
    end
  endtask

  // Drop valid, wait for every predicted byte, then give pixels that make
  // no byte time to clear the compute stage.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (bytes_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly uniform gray, with the threshold neighbors and the rails mixed in.
  function automatic logic [7:0] pick_gray();
    logic [7:0] g;
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0:       g = 8'd0;
          1:       g = 8'd255;
          2:       g = 8'd127;
          default: g = 8'd128;
        endcase
      end
      default: g = 8'($urandom);
    endcase
    return g;
  endfunction

  initial begin
    logic [10:0] w;
    logic [15:0] h;
    logic        d;
    logic        m;
    logic        inv;
    int          n_pix;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Small frame, 3 x 3, dither on: first row reads nothing from above,
    // threshold edges, partial bytes at every row end, frame wrap.
    load_regs(11'd3, 16'd3, 1'b1, 1'b1, 1'b0);
    push_pixel(8'd0);
    push_pixel(8'd255);
    push_pixel(8'd128);
    push_pixel(8'd127);
    push_pixel(8'd255);
    push_pixel(8'd0);
    push_pixel(8'd128);
    push_pixel(8'd128);
    push_pixel(8'd127);
    drain();

    // Width and height of zero act as one; plain threshold, LSB first, inverted.
    load_regs(11'd0, 16'd0, 1'b0, 1'b0, 1'b1);
    push_pixel(8'd255);
    push_pixel(8'd0);
    push_pixel(8'd128);
    push_pixel(8'd127);
    drain();

    // Width above the line store acts as its size. Stop mid-row, then lower
    // the width below the current column: the next pixel closes the row.
    load_regs(11'd2047, 16'd2, 1'b1, 1'b1, 1'b0);
    repeat (9) push_pixel(pick_gray());
    drain();
    load_regs(11'd5, 16'd2, 1'b1, 1'b1, 1'b0);
    repeat (6) push_pixel(pick_gray());
    drain();

    // Random phases, cycling through the idle patterns.
    for (int p = 0; p < 9; p++) begin
      case (p % 4)
        0: begin
          send_gap_pct = 0;
          stall_pct    = 0;
        end
        1: begin
          send_gap_pct = 83;
          stall_pct    = 0;
        end
        2: begin
          send_gap_pct = 0;
          stall_pct    = 83;
        end
        default: begin
          send_gap_pct = 36;
          stall_pct    = 36;
        end
      endcase

      // Geometry may only change at a frame start, or the next row would read
      // line store entries nobody wrote. To get there, shrink to 1 x 1: the
      // next pixel is then the last of its row and of its frame.
      if (col_at != 0 || row_at != 0) begin
        load_regs(11'd1, 16'd1, dither_now, msb_now, invert_now);
        push_pixel(pick_gray());
        drain();
      end

      case ($urandom_range(7))
        0:       w = 11'($urandom_range(1000, 2047));
        1:       w = 11'd1;
        2:       w = 11'd8;
        default: w = 11'($urandom_range(2, 40));
      endcase
      case ($urandom_range(3))
        0:       h = 16'd1;
        1:       h = 16'd65535;
        default: h = 16'($urandom_range(2, 6));
      endcase
      d     = ($urandom_range(3) != 0);
      m     = 1'($urandom);
      inv   = 1'($urandom);
      n_pix = $urandom_range(10, 30);
      if (p == 1) h = 16'd65535;
      if (p == 2) d = 1'b0;
      // one full-width row and a bit of the next, to reach the last column
      if (p == 5) begin
        w     = 11'd1024;
        h     = 16'd2;
        d     = 1'b1;
        n_pix = 1040;
      end

      load_regs(w, h, d, m, inv);
      repeat (n_pix) push_pixel(pick_gray());
      drain();
    end

    if (fail_count == 0) begin
      $display("[error_diffusion_bitmap_packer] OK");
    end else begin
      $display("[error_diffusion_bitmap_packer] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("[error_diffusion_bitmap_packer] ERROR");
    $finish;
  end

endmodule
